### hw/rtl/rgbpdr_pkg.sv
// Shared types and constants for the RGB pixel depth reducer.
package rgbpdr_pkg;

    localparam int PIXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int SLOT_W     = 6;
    localparam int IDX_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // Output modes.
    localparam logic [2:0] MODE_32BPP  = 3'd0;
    localparam logic [2:0] MODE_24BPP  = 3'd1;
    localparam logic [2:0] MODE_16BPP  = 3'd2;
    localparam logic [2:0] MODE_8BPP   = 3'd3;
    localparam logic [2:0] MODE_PSEUDO = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_POS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_POS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_POS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_DROP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_DROP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_DROP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_BITS = 3'd7;

    // Commands.
    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    // Default channel positions of the source layout.
    localparam logic [4:0] DEF_RED_POS   = 5'd16;
    localparam logic [4:0] DEF_GREEN_POS = 5'd8;
    localparam logic [4:0] DEF_BLUE_POS  = 5'd0;

    localparam logic [1:0] DEF_PALETTE_BITS = 2'd2;

    typedef struct packed {
        logic [2:0] output_mode;
        logic [4:0] red_position;
        logic [4:0] green_position;
        logic [4:0] blue_position;
        logic [2:0] red_drop_bits;
        logic [2:0] green_drop_bits;
        logic [2:0] blue_drop_bits;
        logic [1:0] palette_bits;
    } cfg_t;

    typedef struct packed {
        logic               has_result;
        logic               use_palette;
        logic [PIXEL_W-1:0] value;
        logic [IDX_W-1:0]   pal_index;
    } conv_t;

endpackage

### hw/rtl/rgbpdr_if.sv
// Valid/ready channel interfaces for pixel input and pixel output words.
interface rgbpdr_in_if
    import rgbpdr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               command;
    logic [PIXEL_W-1:0] source_pixel;
    logic [SLOT_W-1:0]  palette_slot;
    logic [CHAN_W-1:0]  palette_pixel;

    modport source (output valid, output command, output source_pixel,
                    output palette_slot, output palette_pixel, input ready);
    modport sink   (input valid, input command, input source_pixel,
                    input palette_slot, input palette_pixel, output ready);
endinterface

interface rgbpdr_out_if
    import rgbpdr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] packed_pixel;

    modport source (output valid, output packed_pixel, input ready);
    modport sink   (input valid, input packed_pixel, output ready);
endinterface

### hw/rtl/rgb_pixel_depth_reducer.sv
// Top level of the RGB pixel depth reducer.
//
// Converts 32-bit ARGB source pixels (alpha 31:24, red 23:16, green 15:8,
// blue 7:0) into one of five display formats chosen by output_mode.
// Input words arrive on pix_in; a word with command set stores palette_pixel
// at palette_slot and produces no output word. Converted pixels leave on
// pix_out. Both channels use a valid/ready handshake.
// Configuration is written through cfg_we, cfg_index and cfg_data; register i
// of the register list has index i. The user must write it only while the
// block is idle; the block itself does not enforce this. A converted pixel
// passes one input register stage and one result stage, the latter matching
// the registered read of the palette RAM. Throughput is one word per clock
// while the receiver does not stall.
// When the receiver stalls, the result stage holds its word and the input
// stage can still take one more word; pix_in.ready then drops.
// Reset clears the pipeline valid bits and loads the register defaults
// (32bpp, positions 16/8/0, no drop, two palette bits per channel). The
// palette RAM is not cleared and must be loaded before pseudocolor use.
module rgb_pixel_depth_reducer
    import rgbpdr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rgbpdr_in_if.sink             pix_in,
    rgbpdr_out_if.source          pix_out
);
    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] PAL_LIMIT = IDX_W'(PALETTE_ENTRIES);

    cfg_t cfg_reg;

    logic               s1_valid_reg;
    logic               s1_command_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [CHAN_W-1:0]  s1_palpix_reg;

    logic               s2_valid_reg;
    logic               s2_use_pal_reg;
    logic               s2_in_range_reg;
    logic [PIXEL_W-1:0] s2_value_reg;

    conv_t             conv;
    logic              s2_adv;
    logic              s1_adv;
    logic              pal_we;
    logic [CHAN_W-1:0] pal_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_mode     <= MODE_32BPP;
            cfg_reg.red_position    <= DEF_RED_POS;
            cfg_reg.green_position  <= DEF_GREEN_POS;
            cfg_reg.blue_position   <= DEF_BLUE_POS;
            cfg_reg.red_drop_bits   <= 3'd0;
            cfg_reg.green_drop_bits <= 3'd0;
            cfg_reg.blue_drop_bits  <= 3'd0;
            cfg_reg.palette_bits    <= DEF_PALETTE_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OUTPUT_MODE:  cfg_reg.output_mode     <= cfg_data[2:0];
                REG_RED_POS:      cfg_reg.red_position    <= cfg_data;
                REG_GREEN_POS:    cfg_reg.green_position  <= cfg_data;
                REG_BLUE_POS:     cfg_reg.blue_position   <= cfg_data;
                REG_RED_DROP:     cfg_reg.red_drop_bits   <= cfg_data[2:0];
                REG_GREEN_DROP:   cfg_reg.green_drop_bits <= cfg_data[2:0];
                REG_BLUE_DROP:    cfg_reg.blue_drop_bits  <= cfg_data[2:0];
                REG_PALETTE_BITS: cfg_reg.palette_bits    <= cfg_data[1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Each stage moves when the stage after it is free or draining.
    assign s2_adv       = !s2_valid_reg || pix_out.ready;
    assign s1_adv       = !s1_valid_reg || s2_adv;
    assign pix_in.ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && pix_in.valid)
        begin
            s1_command_reg <= pix_in.command;
            s1_pixel_reg   <= pix_in.source_pixel;
            s1_slot_reg    <= pix_in.palette_slot;
            s1_palpix_reg  <= pix_in.palette_pixel;
        end
    end

    rgbpdr_convert u_convert (
        .cfg   (cfg_reg),
        .pixel (s1_pixel_reg),
        .conv  (conv)
    );

    // Palette writes retire from the input stage and never reach the output.
    assign pal_we = s1_valid_reg && s2_adv && (s1_command_reg == CMD_PAL_WRITE)
                 && ({{(IDX_W-SLOT_W){1'b0}}, s1_slot_reg} < PAL_LIMIT);

    rgbpdr_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (s1_slot_reg[AW-1:0]),
        .wdata (s1_palpix_reg),
        .re    (s2_adv),
        .raddr (conv.pal_index[AW-1:0]),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg && (s1_command_reg == CMD_CONVERT)
                         && conv.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_use_pal_reg  <= conv.use_palette;
            s2_in_range_reg <= conv.pal_index < PAL_LIMIT;
            s2_value_reg    <= conv.value;
        end
    end

    assign pix_out.valid        = s2_valid_reg;
    assign pix_out.packed_pixel = !s2_use_pal_reg ? s2_value_reg
                                : (s2_in_range_reg ? {{(PIXEL_W-CHAN_W){1'b0}}, pal_rdata}
                                                   : '0);
endmodule

### hw/rtl/rgbpdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgbpdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/rgbpdr_convert.sv
// Combinational pixel conversion for all output modes and the palette index.
module rgbpdr_convert
    import rgbpdr_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [PIXEL_W-1:0] pixel,
    output conv_t              conv
);
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  red_s;
    logic [CHAN_W-1:0]  green_s;
    logic [CHAN_W-1:0]  blue_s;
    logic [PIXEL_W-1:0] sum;
    logic [23:0]        word24;
    logic [3:0]         pal_shift;
    logic [CHAN_W-1:0]  red_k;
    logic [CHAN_W-1:0]  green_k;
    logic [CHAN_W-1:0]  blue_k;
    logic               reduce;
    logic               default_pos;

    // Byte lane of a channel in 24bpp mode; 3 means the channel is dropped.
    function automatic logic [1:0] slot24(input logic [4:0] pos);
        logic [1:0] s;
        if (pos == 5'd0)
        begin
            s = 2'd2;
        end
        else if (pos <= 5'd8)
        begin
            s = 2'd1;
        end
        else if (pos <= 5'd23)
        begin
            s = 2'd0;
        end
        else
        begin
            s = 2'd3;
        end
        return s;
    endfunction

    function automatic logic [23:0] place24(input logic [23:0] acc,
                                            input logic [4:0] pos,
                                            input logic [CHAN_W-1:0] c);
        logic [23:0] r;
        r = acc;
        case (slot24(pos))
            2'd0:    r[7:0]   = c;
            2'd1:    r[15:8]  = c;
            2'd2:    r[23:16] = c;
            default: r = acc;
        endcase
        return r;
    endfunction

    always_comb
    begin
        red   = pixel[23:16];
        green = pixel[15:8];
        blue  = pixel[7:0];

        reduce = (cfg.output_mode == MODE_16BPP) || (cfg.output_mode == MODE_8BPP);
        red_s   = reduce ? (red >> cfg.red_drop_bits) : red;
        green_s = reduce ? (green >> cfg.green_drop_bits) : green;
        blue_s  = reduce ? (blue >> cfg.blue_drop_bits) : blue;

        // Channels may overlap; the sum wraps at 32 bits.
        sum = (PIXEL_W'(red_s) << cfg.red_position)
            + (PIXEL_W'(green_s) << cfg.green_position)
            + (PIXEL_W'(blue_s) << cfg.blue_position);

        word24 = 24'd0;
        word24 = place24(word24, cfg.red_position, red);
        word24 = place24(word24, cfg.green_position, green);
        word24 = place24(word24, cfg.blue_position, blue);

        // Keep the top k bits of each channel for the palette index.
        pal_shift = 4'd8 - {2'b00, cfg.palette_bits};
        red_k   = red >> pal_shift;
        green_k = green >> pal_shift;
        blue_k  = blue >> pal_shift;

        default_pos = (cfg.red_position == DEF_RED_POS)
                   && (cfg.green_position == DEF_GREEN_POS)
                   && (cfg.blue_position == DEF_BLUE_POS);

        conv.pal_index = (IDX_W'(red_k) << {cfg.palette_bits, 1'b0})
                       + (IDX_W'(green_k) << cfg.palette_bits)
                       + IDX_W'(blue_k);
        conv.has_result  = 1'b1;
        conv.use_palette = 1'b0;
        conv.value       = '0;

        case (cfg.output_mode)
            MODE_32BPP:  conv.value = default_pos ? pixel : sum;
            MODE_24BPP:  conv.value = {8'd0, word24};
            MODE_16BPP:  conv.value = {16'd0, sum[15:0]};
            MODE_8BPP:   conv.value = {24'd0, sum[7:0]};
            MODE_PSEUDO: conv.use_palette = 1'b1;
            default:     conv.has_result = 1'b0;
        endcase
    end
endmodule
